>>> rtl/min_tracking_stack_macros.svh
// assertion macros shared by the stack design
`ifndef MIN_TRACKING_STACK_MACROS_SVH
`define MIN_TRACKING_STACK_MACROS_SVH

// a property that must hold at every clock edge out of reset
`define MTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// a condition that forces a consequence on the following edge
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/mts_pkg.sv
package mts_pkg;

  // input transaction layout
  localparam int PUSH_W     = 32;
  localparam int IN_DATA_W  = 32;

  // output transaction layout
  localparam int MIN_W      = 32;
  localparam int DEPTH_W    = 9;
  localparam int STATUS_W   = 2;
  localparam int OUT_DATA_W = 48;
  localparam int MIN_LSB    = 0;
  localparam int VALID_BIT  = MIN_LSB + MIN_W;
  localparam int DEPTH_LSB  = VALID_BIT + 1;
  localparam int STATUS_LSB = DEPTH_LSB + DEPTH_W;
  localparam int PAD_W      = OUT_DATA_W - STATUS_LSB - STATUS_W;

  // operation kinds
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL  = 2'd2;

endpackage

>>> rtl/min_tracking_stack.sv
// min tracking stack: a push or an error (pop of an empty stack, push to a full one)
// places its result in the output register at the accepting edge; a pop of a non-empty
// stack first reads the memories into rd_val/rd_min, then in the reload state reloads
// the cached top registers and registers its result; throughput is one push per cycle while the output is not stalled
// reset clears both counts and the output valid; memory contents are not cleared
module min_tracking_stack #(
  parameter int STACK_DEPTH = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [mts_pkg::IN_DATA_W-1:0]  s_tdata,   // push_value [31:0]
  input  logic                           s_tuser,   // kind [0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mts_pkg::OUT_DATA_W-1:0] m_tdata    // current_min [31:0], min_valid [32],
                                                    // stack_depth [41:33], status [43:42]
);
  import mts_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // storage and cached tops
  logic [VALUE_WIDTH-1:0] vmem [STACK_DEPTH];
  logic [VALUE_WIDTH-1:0] mmem [STACK_DEPTH];
  logic [VALUE_WIDTH-1:0] val_top;
  logic [VALUE_WIDTH-1:0] min_top;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [VALUE_WIDTH-1:0] rd_min;
  logic [CW-1:0]          vc;
  logic [CW-1:0]          mc;
  logic                   busy;
  logic                   load_min;

  logic                   accept;
  logic                   is_pop;
  logic                   full;
  logic                   push_ok;
  logic                   push_min;
  logic                   pop_ok;
  logic                   pop_min;
  logic [VALUE_WIDTH-1:0] v_in;
  logic [CW-1:0]          vc_m2;
  logic [CW-1:0]          mc_m2;

  logic [VALUE_WIDTH-1:0] o_min;
  logic                   o_valid;
  logic [CW-1:0]          o_count;
  logic [STATUS_W-1:0]    o_status;

  // handshake and operation decode
  assign s_tready = !busy && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign is_pop   = (s_tuser == KIND_POP);
  assign full     = (vc == CW'(STACK_DEPTH));
  assign v_in     = VALUE_WIDTH'($signed(s_tdata[PUSH_W-1:0]));
  assign push_ok  = accept && !is_pop && !full;
  assign push_min = push_ok && ((mc == '0) || ($signed(v_in) <= $signed(min_top)));
  assign pop_ok   = accept && is_pop && (vc != '0);
  assign pop_min  = pop_ok && (val_top == min_top);
  assign vc_m2    = vc - CW'(2);
  assign mc_m2    = mc - CW'(2);

  // value and minimum memories
  always_ff @(posedge clk) begin
    if (push_ok) begin
      vmem[vc[AW-1:0]] <= v_in;
    end
    if (push_min) begin
      mmem[mc[AW-1:0]] <= v_in;
    end
    if (pop_ok) begin
      rd_val <= vmem[vc_m2[AW-1:0]];
      rd_min <= mmem[mc_m2[AW-1:0]];
    end
  end

  // counts, reload sequencing and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vc       <= '0;
      mc       <= '0;
      busy     <= 1'b0;
      load_min <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (push_ok) begin
        vc <= vc + CW'(1);
        if (push_min) begin
          mc <= mc + CW'(1);
        end
      end else if (pop_ok) begin
        vc <= vc - CW'(1);
        if (pop_min) begin
          mc <= mc - CW'(1);
        end
      end
      busy     <= pop_ok;
      load_min <= pop_min;
      if ((accept && !pop_ok) || busy) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // cached top registers
  always_ff @(posedge clk) begin
    if (push_ok) begin
      val_top <= v_in;
      if (push_min) begin
        min_top <= v_in;
      end
    end else if (busy) begin
      val_top <= rd_val;
      if (load_min) begin
        min_top <= rd_min;
      end
    end
  end

  // result fields, from the accepting cycle or from the reload cycle
  always_comb begin
    if (busy) begin
      o_valid  = (mc != '0);
      o_min    = load_min ? rd_min : min_top;
      o_count  = vc;
      o_status = ST_OK;
    end else begin
      o_valid  = push_min || (mc != '0);
      o_min    = push_min ? v_in : min_top;
      o_count  = push_ok ? (vc + CW'(1)) : vc;
      if (is_pop) begin
        o_status = ST_POP_EMPTY;
      end else if (full) begin
        o_status = ST_PUSH_FULL;
      end else begin
        o_status = ST_OK;
      end
    end
    if (!o_valid) begin
      o_min = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if ((accept && !pop_ok) || busy) begin
      m_tdata <= {{PAD_W{1'b0}}, o_status, DEPTH_W'(o_count), o_valid, MIN_W'(o_min)};
    end
  end

  // checks
  `include "min_tracking_stack_macros.svh"

  `MTS_ASSERT(a_min_le_val, mc <= vc, "minimum stack deeper than value stack")
  `MTS_ASSERT(a_empty_match, (vc == '0) == (mc == '0), "stack and minimum stack disagree on empty")
  `MTS_ASSERT(a_busy_stall, !(busy && s_tready), "input accepted during reload cycle")
  `MTS_ASSERT_NEXT(a_pop_reload, pop_ok, busy && m_tvalid == 1'b0, "pop did not start a reload")
  `MTS_ASSERT_NEXT(a_reload_out, busy, m_tvalid && !busy, "reload did not present a result")

endmodule
